// File: rtl/fsk_tone_correlator_top_macros.svh
// Assertion macros used by the checker file.
`ifndef FSK_TONE_CORRELATOR_TOP_MACROS_SVH
`define FSK_TONE_CORRELATOR_TOP_MACROS_SVH

// Checked at every rising edge outside reset.
`define FSKTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define FSKTC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fsktc_pkg.sv
package fsktc_pkg;

    localparam int unsigned TAP_COUNT = 8;
    localparam int unsigned ADDR_W    = 3;

    localparam logic REG_DETECT_THRESHOLD = 1'b0;

    localparam logic [7:0] SAMPLE_BIAS       = 8'd127;
    localparam logic [7:0] DEFAULT_THRESHOLD = 8'd10;

    typedef logic [$clog2(TAP_COUNT)-1:0] tap_idx_t;

    typedef struct packed {
        logic [7:0] c4;
        logic [7:0] c3;
        logic [7:0] c2;
        logic [7:0] c1;
    } coef_t;

    typedef struct packed {
        logic [15:0] s4;
        logic [15:0] s3;
        logic [15:0] s2;
        logic [15:0] s1;
    } quad_t;

    function automatic coef_t tap_coef(input tap_idx_t idx);
        coef_t c;
        case (idx)
            3'd0: c = '{c1: 8'h40, c2: 8'h00, c3: 8'h40, c4: 8'h00};
            3'd1: c = '{c1: 8'h2D, c2: 8'h2D, c3: 8'h08, c4: 8'h3F};
            3'd2: c = '{c1: 8'h00, c2: 8'h40, c3: 8'hC2, c4: 8'h11};
            3'd3: c = '{c1: 8'hD3, c2: 8'h2D, c3: 8'hE8, c4: 8'hC5};
            3'd4: c = '{c1: 8'hC0, c2: 8'h00, c3: 8'h37, c4: 8'hE0};
            3'd5: c = '{c1: 8'hD3, c2: 8'hD3, c3: 8'h27, c4: 8'h33};
            3'd6: c = '{c1: 8'h00, c2: 8'hC0, c3: 8'hD3, c4: 8'h2D};
            3'd7: c = '{c1: 8'h2D, c2: 8'hD3, c3: 8'hCD, c4: 8'hD9};
            default: c = '0;
        endcase
        return c;
    endfunction

    // Arithmetic shift right by 8 of a 16-bit sum, then magnitude (0 to 128).
    function automatic logic [7:0] fold_mag(input logic [15:0] s);
        logic [7:0] hi;
        hi = s[15:8];
        return hi[7] ? 8'(~hi + 8'd1) : hi;
    endfunction

endpackage

// File: rtl/fsktc_cell.sv
module fsktc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic [7:0]          sample_in,
    input  fsktc_pkg::coef_t    coef,
    output logic [7:0]          sample_out,
    output fsktc_pkg::quad_t    prod
);

    logic [7:0]  sample_reg;
    logic [7:0]  sample_next;
    logic [15:0] x_ext;

    function automatic logic [15:0] mul_tap(input logic [15:0] x, input logic [7:0] c);
        logic [15:0] c_ext;
        c_ext = {{8{c[7]}}, c};
        return 16'(x * c_ext);
    endfunction

    assign sample_next = shift ? sample_in : sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    assign x_ext      = {{8{sample_reg[7]}}, sample_reg};
    assign sample_out = sample_reg;
    assign prod.s1    = mul_tap(x_ext, coef.c1);
    assign prod.s2    = mul_tap(x_ext, coef.c2);
    assign prod.s3    = mul_tap(x_ext, coef.c3);
    assign prod.s4    = mul_tap(x_ext, coef.c4);

endmodule

// File: rtl/fsktc_sum.sv
module fsktc_sum (
    input  logic                clk,
    input  logic                load,
    input  fsktc_pkg::quad_t    prod [fsktc_pkg::TAP_COUNT],
    output fsktc_pkg::quad_t    sums
);

    fsktc_pkg::quad_t sums_reg;
    fsktc_pkg::quad_t sums_next;

    always_comb
    begin
        sums_next = sums_reg;
        if (load)
        begin
            sums_next = '0;
            for (int k = 0; k < fsktc_pkg::TAP_COUNT; k++)
            begin
                sums_next.s1 = 16'(sums_next.s1 + prod[k].s1);
                sums_next.s2 = 16'(sums_next.s2 + prod[k].s2);
                sums_next.s3 = 16'(sums_next.s3 + prod[k].s3);
                sums_next.s4 = 16'(sums_next.s4 + prod[k].s4);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sums_reg <= sums_next;
    end

    assign sums = sums_reg;

endmodule

// File: rtl/fsktc_decide.sv
module fsktc_decide (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  fsktc_pkg::quad_t    sums,
    input  logic [7:0]          threshold,
    output logic                tone_bit,
    output logic signed [9:0]   tone_metric
);

    logic               bit_reg;
    logic               bit_next;
    logic signed [9:0]  metric_reg;
    logic signed [9:0]  metric_next;
    logic [7:0]         mag1;
    logic [7:0]         mag2;
    logic [7:0]         mag3;
    logic [7:0]         mag4;
    logic signed [9:0]  metric;
    logic signed [9:0]  thr_pos;
    logic signed [9:0]  thr_neg;

    always_comb
    begin
        mag1   = fsktc_pkg::fold_mag(sums.s1);
        mag2   = fsktc_pkg::fold_mag(sums.s2);
        mag3   = fsktc_pkg::fold_mag(sums.s3);
        mag4   = fsktc_pkg::fold_mag(sums.s4);
        metric = 10'({2'b00, mag3} + {2'b00, mag4} - {2'b00, mag1} - {2'b00, mag2});
        thr_pos = {2'b00, threshold};
        thr_neg = 10'(-thr_pos);

        bit_next    = bit_reg;
        metric_next = metric_reg;
        if (load)
        begin
            metric_next = metric;
            if (metric > thr_pos)
            begin
                bit_next = 1'b1;
            end
            else if (metric < thr_neg)
            begin
                bit_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        metric_reg <= metric_next;
    end

    assign tone_bit    = bit_reg;
    assign tone_metric = metric_reg;

endmodule

// File: rtl/fsk_tone_correlator_top.sv
// Channel      Handshake                      Payload
// config       psel penable pwrite pready     paddr pwdata prdata
// input        in_valid / in_ready            adc_sample
// output       out_valid / out_ready          tone_bit tone_metric
//
// One item is taken per cycle while the output is not stalled.
// The sample chain shifts on acceptance and the correlation sums are registered
// before the fold and hysteresis stage, which writes the output register.
// Reset clears the sample chain, the held bit and the stage valids, and sets
// the threshold to ten. A stalled output holds the pipeline back stage by stage.
module fsk_tone_correlator_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fsktc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   adc_sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         tone_bit,
    output logic signed [9:0]            tone_metric
);

    logic [7:0]       thr_reg;
    logic [7:0]       thr_next;
    logic             win_valid_reg;
    logic             win_valid_next;
    logic             sum_valid_reg;
    logic             sum_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             sum_load;
    logic             out_load;
    logic             thr_sel;
    logic [7:0]       new_sample;
    logic [7:0]       chain_in  [fsktc_pkg::TAP_COUNT];
    logic [7:0]       chain_out [fsktc_pkg::TAP_COUNT];
    fsktc_pkg::quad_t prod      [fsktc_pkg::TAP_COUNT];
    fsktc_pkg::quad_t sums;

    assign pready  = 1'b1;
    assign thr_sel = (paddr[fsktc_pkg::ADDR_W-1] == fsktc_pkg::REG_DETECT_THRESHOLD);
    assign prdata  = thr_sel ? {24'd0, thr_reg} : 32'd0;
    assign thr_next = (psel && penable && pwrite && thr_sel) ? pwdata[7:0] : thr_reg;

    assign out_load = sum_valid_reg && (!out_valid_reg || out_ready);
    assign sum_load = win_valid_reg && (!sum_valid_reg || out_load);
    assign in_ready = !win_valid_reg || sum_load;
    assign accept   = in_valid && in_ready;

    assign win_valid_next = accept   ? 1'b1 : (sum_load ? 1'b0 : win_valid_reg);
    assign sum_valid_next = sum_load ? 1'b1 : (out_load ? 1'b0 : sum_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= fsktc_pkg::DEFAULT_THRESHOLD;
            win_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            win_valid_reg <= win_valid_next;
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign new_sample = adc_sample - fsktc_pkg::SAMPLE_BIAS;

    for (genvar k = 0; k < fsktc_pkg::TAP_COUNT; k++)
    begin : g_cell
        if (k == fsktc_pkg::TAP_COUNT - 1)
        begin : g_head
            assign chain_in[k] = new_sample;
        end
        else
        begin : g_link
            assign chain_in[k] = chain_out[k+1];
        end

        fsktc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (accept),
            .sample_in  (chain_in[k]),
            .coef       (fsktc_pkg::tap_coef(fsktc_pkg::tap_idx_t'(k))),
            .sample_out (chain_out[k]),
            .prod       (prod[k])
        );
    end

    fsktc_sum u_sum (
        .clk  (clk),
        .load (sum_load),
        .prod (prod),
        .sums (sums)
    );

    fsktc_decide u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .sums        (sums),
        .threshold   (thr_reg),
        .tone_bit    (tone_bit),
        .tone_metric (tone_metric)
    );

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/fsktc_checker.sv
`include "fsk_tone_correlator_top_macros.svh"

module fsktc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              tone_bit,
    input logic signed [9:0] tone_metric
);

    `FSKTC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "Output valid during reset")
    `FSKTC_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(tone_bit) && $stable(tone_metric), "Stalled result changed")
    `FSKTC_ASSERT(a_metric_range, out_valid |-> (tone_metric <= 10'sd256 && tone_metric >= -10'sd256), "Metric out of range")
    `FSKTC_ASSERT(a_bit_rise, $rose(tone_bit) |-> out_valid && tone_metric > 10'sd0, "Bit set without a positive metric")
    `FSKTC_ASSERT(a_bit_fall, $fell(tone_bit) |-> out_valid && tone_metric < 10'sd0, "Bit cleared without a negative metric")

endmodule

bind fsk_tone_correlator_top fsktc_checker u_fsktc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tone_bit    (tone_bit),
    .tone_metric (tone_metric)
);
